>>> rtl/cti_pkg.sv
// ============================================================================
// cti_pkg
// Shared types and constants of the CLAHE tile interpolation block.
// ============================================================================
`default_nettype none

package cti_pkg;

  // Grid limits and field widths
  localparam int TD_MAX      = 8;                    // tile rows
  localparam int TA_MAX      = 8;                    // tile columns
  localparam int LEVELS      = 256;                  // map entries per tile
  localparam int TILE_SLOTS  = TD_MAX * TA_MAX;
  localparam int TILE_IDX_W  = $clog2(TILE_SLOTS);
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int MAP_ADDR_W  = TILE_IDX_W + LVL_W;
  localparam int MAP_DEPTH   = TILE_SLOTS * LEVELS;
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 10;                   // tile height / width
  localparam int CNT_W       = 4;                    // tile counts and tile coordinates
  localparam int NMUL        = 2 ** CNT_W;           // entries of the multiple tables
  localparam int MULT_W      = 13;                   // k * tile size, k < NMUL
  localparam int AMUL_W      = 2 * CNT_W - 1;        // k * tiles_across

  localparam int DIM_MIN     = 2;
  localparam int DIM_MAX     = 512;

  // Datapath widths
  localparam int WGT_W       = 2 * DIM_W;            // area weight
  localparam int TERM_W      = WGT_W + PIX_W;        // weight * map value
  localparam int SUM_W       = TERM_W + 2;           // four terms
  localparam int DEN_W       = 2 * DIM_W - 1;        // area, at most 512*512
  localparam int NUM_W       = SUM_W + 1;            // 2*sum + den
  localparam int DIV_D_W     = DEN_W + 1;            // 2*den
  localparam int Q_W         = PIX_W;                // quotient bits

  // Cycles from the accepting edge to the edge that takes the result
  localparam int LATENCY     = 4 + Q_W;

  // Configuration register indexes
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_HEIGHT  = 2'd0,
    CFG_TILE_WIDTH   = 2'd1,
    CFG_TILES_DOWN   = 2'd2,
    CFG_TILES_ACROSS = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/cti_ram.sv
// ============================================================================
// cti_ram
// Generic single-write, dual-read RAM with registered, read-first outputs.
// ============================================================================
`default_nettype none

module cti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // reads return the contents before a write at the same edge
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cti_div.sv
// ============================================================================
// cti_div
// Pipelined restoring divider, one quotient bit per stage, for a quotient
// known to fit in Q_W bits.
// ============================================================================
`default_nettype none

module cti_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [cti_pkg::NUM_W-1:0]   num_i,
  input  wire logic [cti_pkg::DIV_D_W-1:0] den_i,
  output logic                             valid_o,
  output logic      [cti_pkg::Q_W-1:0]     quot_o
);

  localparam int QW = cti_pkg::Q_W;

  logic [cti_pkg::NUM_W-1:0]   rem_q [QW-1];
  logic [cti_pkg::DIV_D_W-1:0] den_q [QW-1];
  logic [QW-1:0]               quo_q [QW];
  logic [QW-1:0]               vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [cti_pkg::NUM_W-1:0]   rem_in;
    logic [cti_pkg::NUM_W-1:0]   dsh;
    logic [cti_pkg::DIV_D_W-1:0] den_in;
    logic [QW-1:0]               quo_in;
    logic                        v_in;
    logic                        ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign v_in   = vld_q[s-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign dsh = cti_pkg::NUM_W'(den_in) << (QW - 1 - s);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= {quo_in[QW-2:0], ge};
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? rem_in - dsh : rem_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];

endmodule

`default_nettype wire

>>> rtl/clahe_tile_interpolation_top.sv
// ============================================================================
// clahe_tile_interpolation_top
// Per-tile intensity maps with bilinear blending between tile centers.
// ============================================================================
// Results: a pixel transaction gives its result strobe once it has passed stages
//   A to D and the divider stages; a load transaction gives no result.
// Throughput: one transaction per clock; busy is never raised. The four map
//   reads of a pixel come from two copies of the map RAM, two ports each.
// Reset: configuration returns to 64x64 tiles on an 8x8 grid and the pipeline
//   empties; the map RAM is not cleared.
`default_nettype none

module clahe_tile_interpolation_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           mode_i,
  input  wire logic [cti_pkg::TILE_IDX_W-1:0] tile_number_i,
  input  wire logic [cti_pkg::LVL_W-1:0]      level_i,
  input  wire logic [cti_pkg::PIX_W-1:0]      value_i,
  input  wire logic [cti_pkg::COORD_W-1:0]    row_i,
  input  wire logic [cti_pkg::COORD_W-1:0]    column_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [cti_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cti_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                valid_o,
  output logic      [cti_pkg::PIX_W-1:0]      intensity_o
);

  localparam int DW = cti_pkg::DIM_W;
  localparam int CW = cti_pkg::CNT_W;
  localparam int MW = cti_pkg::MULT_W;
  localparam int AW = cti_pkg::AMUL_W;
  localparam int IW = cti_pkg::TILE_IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [DW-1:0] th_q, tw_q;
  logic [CW-1:0] td_q, ta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q <= DW'(64);
      tw_q <= DW'(64);
      td_q <= CW'(cti_pkg::TD_MAX);
      ta_q <= CW'(cti_pkg::TA_MAX);
    end else if (cfg_we_i) begin
      case (cti_pkg::cfg_idx_e'(cfg_idx_i))
        cti_pkg::CFG_TILE_HEIGHT:  th_q <= cfg_data_i;
        cti_pkg::CFG_TILE_WIDTH:   tw_q <= cfg_data_i;
        cti_pkg::CFG_TILES_DOWN:   td_q <= cfg_data_i[CW-1:0];
        cti_pkg::CFG_TILES_ACROSS: ta_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Saturated working copies
  logic [DW-1:0] th_c, tw_c, half_h, half_w;
  logic [CW-1:0] td_c, ta_c;

  always_comb begin
    th_c = (th_q < DW'(cti_pkg::DIM_MIN)) ? DW'(cti_pkg::DIM_MIN) :
           (th_q > DW'(cti_pkg::DIM_MAX)) ? DW'(cti_pkg::DIM_MAX) : th_q;
    tw_c = (tw_q < DW'(cti_pkg::DIM_MIN)) ? DW'(cti_pkg::DIM_MIN) :
           (tw_q > DW'(cti_pkg::DIM_MAX)) ? DW'(cti_pkg::DIM_MAX) : tw_q;
    td_c = (td_q == '0) ? CW'(1) :
           (td_q > CW'(cti_pkg::TD_MAX)) ? CW'(cti_pkg::TD_MAX) : td_q;
    ta_c = (ta_q == '0) ? CW'(1) :
           (ta_q > CW'(cti_pkg::TA_MAX)) ? CW'(cti_pkg::TA_MAX) : ta_q;
    half_h = th_c >> 1;
    half_w = tw_c >> 1;
  end

  // Multiples of tile size and of tiles_across, one per tile coordinate
  logic [MW-1:0] mul_h [cti_pkg::NMUL];
  logic [MW-1:0] mul_w [cti_pkg::NMUL];
  logic [AW-1:0] mul_a [cti_pkg::NMUL];

  always_comb begin
    for (int k = 0; k < cti_pkg::NMUL; k++) begin
      mul_h[k] = MW'(k * int'(th_c));
      mul_w[k] = MW'(k * int'(tw_c));
      mul_a[k] = AW'(k * int'(ta_c));
    end
  end

  // ---------------------------------------------------------------------------
  // Map load: written at the accepting edge
  logic                             acc;
  logic                             map_we;
  logic [cti_pkg::MAP_ADDR_W-1:0]   map_waddr;

  assign busy      = 1'b0;
  assign acc       = start && !busy;
  assign map_we    = acc && !mode_i && ({1'b0, tile_number_i} < mul_a[td_c]);
  assign map_waddr = {tile_number_i, level_i};

  // ---------------------------------------------------------------------------
  // Pixel classification and distances
  logic [MW-1:0] row_x, col_x;
  logic [MW-1:0] bottom, right, cr, cc, nrc, ncc;
  logic [MW-1:0] d_rc, d_rn, d_cc, d_cn;
  logic [CW-1:0] tr, tc, nr, nc;
  logic          in_rows, in_cols;

  always_comb begin
    row_x = MW'(row_i);
    col_x = MW'(column_i);
    tr = '0;
    tc = '0;
    // containing tile: last multiple not above the coordinate
    for (int k = 1; k < cti_pkg::TD_MAX; k++) begin
      if (CW'(k) < td_c && row_x >= mul_h[k]) tr = CW'(k);
    end
    for (int k = 1; k < cti_pkg::TA_MAX; k++) begin
      if (CW'(k) < ta_c && col_x >= mul_w[k]) tc = CW'(k);
    end
    bottom = mul_h[td_c - CW'(1)] + MW'(half_h);
    right  = mul_w[ta_c - CW'(1)] + MW'(half_w);
    cr     = mul_h[tr] + MW'(half_h);
    cc     = mul_w[tc] + MW'(half_w);
    nr     = (row_x < cr) ? tr - CW'(1) : tr + CW'(1);
    nc     = (col_x < cc) ? tc - CW'(1) : tc + CW'(1);
    nrc    = mul_h[nr] + MW'(half_h);
    ncc    = mul_w[nc] + MW'(half_w);
    d_rc   = (row_x > cr)  ? row_x - cr  : cr  - row_x;
    d_rn   = (row_x > nrc) ? row_x - nrc : nrc - row_x;
    d_cc   = (col_x > cc)  ? col_x - cc  : cc  - col_x;
    d_cn   = (col_x > ncc) ? col_x - ncc : ncc - col_x;
    in_rows = (row_x > MW'(half_h)) && (row_x < bottom);
    in_cols = (col_x > MW'(half_w)) && (col_x < right);
  end

  // ---------------------------------------------------------------------------
  // Stage A: tile coordinates and blend factors
  logic                      a_v_q;
  logic [CW-1:0]             a_tr_q, a_tc_q, a_nr_q, a_nc_q;
  logic [DW-1:0]             a_fr0_q, a_fr1_q, a_fc0_q, a_fc1_q, a_dr_q, a_dc_q;
  logic                      a_use_nr_q, a_use_nc_q;
  logic [cti_pkg::LVL_W-1:0] a_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else begin
      a_v_q <= acc && mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_tr_q     <= tr;
    a_tc_q     <= tc;
    a_nr_q     <= nr;
    a_nc_q     <= nc;
    a_fr0_q    <= in_rows ? DW'(d_rn) : DW'(1);
    a_fr1_q    <= in_rows ? DW'(d_rc) : '0;
    a_fc0_q    <= in_cols ? DW'(d_cn) : DW'(1);
    a_fc1_q    <= in_cols ? DW'(d_cc) : '0;
    a_dr_q     <= in_rows ? th_c : DW'(1);
    a_dc_q     <= in_cols ? tw_c : DW'(1);
    a_use_nr_q <= in_rows;
    a_use_nc_q <= in_cols;
    a_lvl_q    <= value_i;
  end

  // Map read addresses: tile row-major index and intensity
  logic [IW-1:0] idx00, idx01, idx10, idx11;

  assign idx00 = IW'(mul_a[a_tr_q] + AW'(a_tc_q));
  assign idx01 = IW'(mul_a[a_tr_q] + AW'(a_nc_q));
  assign idx10 = IW'(mul_a[a_nr_q] + AW'(a_tc_q));
  assign idx11 = IW'(mul_a[a_nr_q] + AW'(a_nc_q));

  logic [cti_pkg::PIX_W-1:0] m00, m01, m10, m11;

  // two identical copies give four reads a cycle
  cti_ram #(
    .WIDTH (cti_pkg::PIX_W),
    .DEPTH (cti_pkg::MAP_DEPTH)
  ) u_map0 (
    .clk_i     (clk_i),
    .we_i      (map_we),
    .waddr_i   (map_waddr),
    .wdata_i   (value_i),
    .raddr_a_i ({idx00, a_lvl_q}),
    .raddr_b_i ({idx01, a_lvl_q}),
    .rdata_a_o (m00),
    .rdata_b_o (m01)
  );

  cti_ram #(
    .WIDTH (cti_pkg::PIX_W),
    .DEPTH (cti_pkg::MAP_DEPTH)
  ) u_map1 (
    .clk_i     (clk_i),
    .we_i      (map_we),
    .waddr_i   (map_waddr),
    .wdata_i   (value_i),
    .raddr_a_i ({idx10, a_lvl_q}),
    .raddr_b_i ({idx11, a_lvl_q}),
    .rdata_a_o (m10),
    .rdata_b_o (m11)
  );

  // ---------------------------------------------------------------------------
  // Stage B: area weights and total area
  logic                        b_v_q, b_use_nr_q, b_use_nc_q;
  logic [cti_pkg::WGT_W-1:0]   b_w00_q, b_w01_q, b_w10_q, b_w11_q;
  logic [cti_pkg::DEN_W-1:0]   b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_w00_q    <= a_fr0_q * a_fc0_q;
    b_w01_q    <= a_fr0_q * a_fc1_q;
    b_w10_q    <= a_fr1_q * a_fc0_q;
    b_w11_q    <= a_fr1_q * a_fc1_q;
    b_den_q    <= cti_pkg::DEN_W'(a_dr_q * a_dc_q);
    b_use_nr_q <= a_use_nr_q;
    b_use_nc_q <= a_use_nc_q;
  end

  // Stage C: weighted map values; unused neighbors read as zero
  logic [cti_pkg::PIX_W-1:0]  m01_e, m10_e, m11_e;
  logic                       c_v_q;
  logic [cti_pkg::TERM_W-1:0] c_t00_q, c_t01_q, c_t10_q, c_t11_q;
  logic [cti_pkg::DEN_W-1:0]  c_den_q;

  assign m01_e = b_use_nc_q ? m01 : '0;
  assign m10_e = b_use_nr_q ? m10 : '0;
  assign m11_e = (b_use_nr_q && b_use_nc_q) ? m11 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_t00_q <= b_w00_q * m00;
    c_t01_q <= b_w01_q * m01_e;
    c_t10_q <= b_w10_q * m10_e;
    c_t11_q <= b_w11_q * m11_e;
    c_den_q <= b_den_q;
  end

  // Stage D: rounding numerator 2*sum + den over 2*den
  logic [cti_pkg::SUM_W-1:0]   sum_d;
  logic                        d_v_q;
  logic [cti_pkg::NUM_W-1:0]   d_num_q;
  logic [cti_pkg::DIV_D_W-1:0] d_den_q;

  assign sum_d = cti_pkg::SUM_W'(c_t00_q) + cti_pkg::SUM_W'(c_t01_q)
               + cti_pkg::SUM_W'(c_t10_q) + cti_pkg::SUM_W'(c_t11_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_num_q <= {sum_d, 1'b0} + cti_pkg::NUM_W'(c_den_q);
    d_den_q <= {c_den_q, 1'b0};
  end

  // Division; the weighted mean never exceeds 255
  cti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_v_q),
    .num_i   (d_num_q),
    .den_i   (d_den_q),
    .valid_o (valid_o),
    .quot_o  (intensity_o)
  );

endmodule

`default_nettype wire

>>> rtl/cti_checker.sv
// ============================================================================
// cti_checker
// Port-level checks of the tile interpolation block, bound to the top level.
// ============================================================================
`default_nettype none

module cti_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic mode_i,
  input wire logic valid_o
);

  // a pixel transaction always yields its result at the fixed latency
  a_pixel_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i) |-> ##(cti_pkg::LATENCY) valid_o)
    else $error("pixel transaction without result");

  // every result traces back to a pixel transaction
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy && mode_i, cti_pkg::LATENCY))
    else $error("result without pixel transaction");

  // a load transaction never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !mode_i) |-> ##(cti_pkg::LATENCY) !valid_o)
    else $error("load transaction produced a result");

endmodule

bind clahe_tile_interpolation_top cti_checker u_cti_checker (.*);

`default_nettype wire
